/* rtl/core/utf8_stream_decoder_unit_defines.svh */
// Assertion macros shared by the decoder RTL.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define USD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("usd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define USD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("usd: next-cycle check failed");

`endif

/* rtl/core/usd_pkg.sv */
// Package for the UTF-8 stream decoder: byte classes, constants, command word.
// No dependencies.
package usd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [7:0]     LEAD2_BASE     = 8'hC0;
  localparam logic [7:0]     LEAD3_BASE     = 8'hE0;
  localparam logic [7:0]     LEAD4_BASE     = 8'hF0;
  localparam logic [7:0]     INVALID_BASE   = 8'hF8;
  localparam logic [7:0]     CONT_BASE      = 8'h80;
  localparam logic [5:0]     CONT_MASK      = 6'h3F;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } usd_class_e;

  // One decoded byte's worth of results: n_rep replacements, then an optional tail.
  typedef struct packed {
    logic [1:0]     n_rep;
    logic           tail_valid;
    logic [CpW-1:0] tail_cp;
    logic           tail_rep;
  } usd_cmd_t;

  function automatic usd_class_e usd_classify(input logic [7:0] b);
    usd_class_e cls;
    priority if (b < CONT_BASE)    cls = CLS_ASCII;
    else if (b < LEAD2_BASE)       cls = CLS_CONT;
    else if (b < LEAD3_BASE)       cls = CLS_LEAD2;
    else if (b < LEAD4_BASE)       cls = CLS_LEAD3;
    else if (b < INVALID_BASE)     cls = CLS_LEAD4;
    else                           cls = CLS_INVALID;
    return cls;
  endfunction

endpackage

/* rtl/core/usd_if.sv */
// Stream interfaces for the decoder: byte input and code point output.
// Valid/ready handshake; no package dependency.
interface usd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface usd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;

  modport source (output valid, output code_point, output replaced, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input last_of_run,
                  output ready);
endinterface

/* rtl/core/utf8_stream_decoder_unit.sv */
// UTF-8 stream decoder top level: front end, command queue, back end.
// Depends on usd_pkg, usd_if, usd_front, usd_cmd_fifo and usd_back.
//
// Takes one UTF-8 byte per cycle while the command queue (FIFO_DEPTH entries)
// has room, and delivers one code point word per cycle while out_o.ready is
// high. The front end updates the open sequence in the same cycle, so bytes
// may follow back to back. Each byte yields 0 to 4 result words, so a byte
// that breaks a sequence occupies the output for up to 4 words while the
// queue keeps absorbing input. A byte's words pass through the queue and the
// back end's command register. Malformed input gives U+FFFD with replaced
// set; last_of_run marks the final word of a byte.
module utf8_stream_decoder_unit #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  usd_in_if.sink    in_i,
  usd_out_if.source out_o
);
  import usd_pkg::*;

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  usd_cmd_t push_cmd;
  usd_cmd_t pop_cmd;

  // byte classification and sequence tracking
  usd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // decoupling queue
  usd_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  // result expansion
  usd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pop_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/core/usd_cmd_fifo.sv */
// Small command queue between the decoder front and back ends.
// Depends on usd_pkg and the assertion macro header.
`include "utf8_stream_decoder_unit_defines.svh"

module usd_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  usd_pkg::usd_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output usd_pkg::usd_cmd_t pop_cmd_o,
  output logic              empty_o
);
  import usd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  usd_cmd_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `USD_ASSERT_NOW(a_no_push_full, push_i, !full_o)
  `USD_ASSERT_NOW(a_no_pop_empty, pop_i, !empty_o)
  `USD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FullCnt)

endmodule

/* rtl/core/usd_front.sv */
// Decoder front end: accepts bytes, tracks the open sequence, emits commands.
// Depends on usd_pkg and the usd_in_if interface.
module usd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  usd_in_if.sink            in_i,
  input  logic              full_i,
  output logic              push_o,
  output usd_pkg::usd_cmd_t push_cmd_o
);
  import usd_pkg::*;

  logic [2:0]     seq_len_q, seq_len_d;
  logic [1:0]     coll_q, coll_d;
  logic [CpW-1:0] part_q, part_d;

  logic           accept;
  usd_class_e     cls;
  usd_cmd_t       cmd;
  logic [1:0]     coll_inc;
  logic [CpW-1:0] part_new;
  logic           do_lead;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign cls        = usd_classify(in_i.in_byte);
  assign coll_inc   = coll_q + 2'd1;
  assign part_new   = {part_q[CpW-7:0], in_i.in_byte[5:0] & CONT_MASK};

  // classify the byte against the open sequence
  always_comb begin
    cmd       = '0;
    seq_len_d = seq_len_q;
    coll_d    = coll_q;
    part_d    = part_q;
    do_lead   = 1'b0;

    if (seq_len_q != 3'd0) begin
      if (cls == CLS_CONT) begin
        if (({1'b0, coll_inc} + 3'd1) >= seq_len_q) begin
          // sequence complete
          cmd.tail_valid = 1'b1;
          cmd.tail_cp    = part_new;
          cmd.tail_rep   = 1'b0;
          seq_len_d      = 3'd0;
          coll_d         = 2'd0;
          part_d         = '0;
        end else if (in_i.end_of_string) begin
          // string ended inside the sequence
          cmd.n_rep = coll_inc + 2'd1;
          seq_len_d = 3'd0;
          coll_d    = 2'd0;
          part_d    = '0;
        end else begin
          coll_d = coll_inc;
          part_d = part_new;
        end
      end else begin
        // broken sequence: flush, then take the byte as a new lead
        cmd.n_rep = coll_q + 2'd1;
        seq_len_d = 3'd0;
        coll_d    = 2'd0;
        part_d    = '0;
        do_lead   = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      unique case (cls)
        CLS_ASCII: begin
          cmd.tail_valid = 1'b1;
          cmd.tail_cp    = {{(CpW-8){1'b0}}, in_i.in_byte};
          cmd.tail_rep   = 1'b0;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (in_i.end_of_string) begin
            cmd.tail_valid = 1'b1;
            cmd.tail_cp    = REPLACEMENT_CP;
            cmd.tail_rep   = 1'b1;
          end else begin
            coll_d = 2'd0;
            unique case (cls)
              CLS_LEAD2: begin
                seq_len_d = 3'd2;
                part_d    = {{(CpW-5){1'b0}}, in_i.in_byte[4:0]};
              end
              CLS_LEAD3: begin
                seq_len_d = 3'd3;
                part_d    = {{(CpW-4){1'b0}}, in_i.in_byte[3:0]};
              end
              default: begin
                seq_len_d = 3'd4;
                part_d    = {{(CpW-3){1'b0}}, in_i.in_byte[2:0]};
              end
            endcase
          end
        end
        default: begin
          // stray continuation or invalid lead
          cmd.tail_valid = 1'b1;
          cmd.tail_cp    = REPLACEMENT_CP;
          cmd.tail_rep   = 1'b1;
        end
      endcase
    end
  end

  assign push_o     = accept && ((cmd.n_rep != 2'd0) || cmd.tail_valid);
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= 3'd0;
      coll_q    <= 2'd0;
      part_q    <= '0;
    end else if (accept) begin
      seq_len_q <= seq_len_d;
      coll_q    <= coll_d;
      part_q    <= part_d;
    end
  end

endmodule

/* rtl/core/usd_back.sv */
// Decoder back end: expands one command into result words, one per cycle while out_o.ready is high.
// Depends on usd_pkg, usd_out_if and the assertion macro header.
`include "utf8_stream_decoder_unit_defines.svh"

module usd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  usd_pkg::usd_cmd_t cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  usd_out_if.source         out_o
);
  import usd_pkg::*;

  usd_cmd_t   cmd_q, cmd_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;

  logic [2:0] total;
  logic       is_last;
  logic       out_fire;
  logic       need_load;

  assign total     = {1'b0, cmd_q.n_rep} + {2'b00, cmd_q.tail_valid};
  assign is_last   = ({1'b0, idx_q} == (total - 3'd1));
  assign out_fire  = busy_q && out_o.ready;
  assign need_load = !busy_q || (out_fire && is_last);
  assign pop_o     = need_load && !empty_i;

  // result word from the held command
  assign out_o.valid       = busy_q;
  assign out_o.code_point  = (idx_q < cmd_q.n_rep) ? REPLACEMENT_CP : cmd_q.tail_cp;
  assign out_o.replaced    = (idx_q < cmd_q.n_rep) ? 1'b1 : cmd_q.tail_rep;
  assign out_o.last_of_run = is_last;

  // load next command or step through the current one
  always_comb begin
    cmd_d  = cmd_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (need_load) begin
      busy_d = !empty_i;
      idx_d  = 2'd0;
      if (!empty_i) begin
        cmd_d = cmd_i;
      end
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  `USD_ASSERT_NOW(a_cmd_nonempty, busy_q, total != 3'd0)
  `USD_ASSERT_NOW(a_idx_in_range, busy_q, {1'b0, idx_q} < total)
  `USD_ASSERT_NEXT(a_idle_after_drain, out_fire && is_last && empty_i, !busy_q)

endmodule
